### design/sha256_stream_hasher_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared assertion helpers for the hasher modules.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// assert that a implies b on the same edge
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// assert that a implies b on the next edge
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### design/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    typedef logic [7:0][31:0] t_hash;

    localparam t_hash INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            unique case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

### design/sha_queue.sv
// ----------------------------------------------------------------------------
// SHA command queue
// Small FIFO between the input front and the compression engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha_queue
    import sha_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= nxt(r_wp);
            if (i_pop && !o_empty) r_rp <= nxt(r_rp);
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

    `SHA_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH))
    `SHA_ASSERT_NEXT(a_full_push, i_clk, i_rst_n, o_full && !i_pop, o_full)
    `SHA_ASSERT_NEXT(a_empty_pop, i_clk, i_rst_n, o_empty && !i_push, o_empty)
endmodule
`default_nettype wire

### design/sha_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 engine
// Byte shift window, one-round-per-cycle compression, padding and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_defines.svh"
module sha_engine
    import sha_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cmd_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last
);
    t_state r_state, n_state;
    t_hash  r_h, n_h;
    t_hash  r_v, n_v;
    logic [15:0][31:0] r_w, n_w;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_t, n_t;
    logic        r_fin, n_fin;
    logic        r_second, n_second;
    logic        r_mark, n_mark;
    logic [2:0]  r_idx, n_idx;

    logic [31:0] wt, s0, s1, t1, sum0, sum1, ch, maj, wnew;
    logic [63:0] total;
    logic [7:0]  sh_byte;
    logic [15:0][31:0] w_shift;

    always_comb begin
        wt   = r_w[0];
        sum1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + sum1 + ch + round_k(r_t) + wt;
        sum0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        s0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wnew = s1 + r_w[9] + s0 + r_w[0];
        total = r_len + {55'd0, r_fill, 3'd0};
        // pad byte: marker, then zeros, then length bytes at the block tail
        if (r_state == ST_PAD) begin
            if (r_mark) sh_byte = 8'h80;
            else if (r_second && r_fill >= 6'd56) sh_byte = r_len[63:56];
            else sh_byte = 8'h00;
        end else begin
            sh_byte = i_cmd.data;
        end
        // bytes enter at the tail; after 64 beats the first byte is w[0] MSB
        for (int i = 0; i < 15; i++) w_shift[i] = {r_w[i][23:0], r_w[i+1][31:24]};
        w_shift[15] = {r_w[15][23:0], sh_byte};
    end

    always_comb begin
        n_state  = r_state;
        n_h      = r_h;
        n_v      = r_v;
        n_w      = r_w;
        n_fill   = r_fill;
        n_len    = r_len;
        n_t      = r_t;
        n_fin    = r_fin;
        n_second = r_second;
        n_mark   = r_mark;
        n_idx    = r_idx;
        o_cmd_pop = 1'b0;
        o_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_ABSORB) begin
                        n_w    = w_shift;
                        n_fill = r_fill + 1'b1;
                        if (r_fill == 6'd63) begin
                            n_fin   = 1'b0;
                            n_state = ST_ROUND;
                            n_t     = '0;
                            n_v     = r_h;
                        end
                    end else begin
                        n_fin    = 1'b1;
                        n_mark   = 1'b1;
                        n_second = (r_fill < 6'd56);
                        n_len    = total;
                        n_state  = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + sum0 + maj;
                for (int i = 0; i < 15; i++) n_w[i] = r_w[i+1];
                n_w[15] = wnew;
                n_t = r_t + 1'b1;
                if (r_t == 6'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) n_h[i] = r_h[i] + r_v[i];
                if (!r_fin) begin
                    n_len   = r_len + 64'd512;
                    n_state = ST_IDLE;
                end else if (r_second) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_second = 1'b1;
                    n_state  = ST_PAD;
                end
            end
            ST_PAD: begin
                n_w    = w_shift;
                n_mark = 1'b0;
                if (!r_mark && r_second && r_fill >= 6'd56) n_len = {r_len[55:0], 8'h00};
                n_fill = r_fill + 1'b1;
                if (r_fill == 6'd63) begin
                    n_v     = r_h;
                    n_t     = '0;
                    n_state = ST_ROUND;
                end
            end
            ST_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd7) begin
                        n_h     = INIT_H;
                        n_len   = '0;
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_digest_word = r_h[r_idx];
    assign o_word_index  = r_idx;
    assign o_last        = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_w      <= n_w;
        r_t      <= n_t;
        r_second <= n_second;
        r_mark   <= n_mark;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h     <= INIT_H;
            r_fill  <= '0;
            r_len   <= '0;
            r_fin   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_h     <= n_h;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_fin   <= n_fin;
            r_idx   <= n_idx;
        end
    end

    `SHA_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_cmd_pop, r_state == ST_IDLE)
    `SHA_ASSERT_NEXT(a_emit_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_word_index))
    `SHA_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, o_valid && o_last && !i_stall,
        r_state == ST_IDLE && r_fill == '0)
endmodule
`default_nettype wire

### design/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with a command queue in front of the round engine.
// ----------------------------------------------------------------------------
// Input beats carry i_op and i_message_byte under i_valid / o_stall. An absorb
// beat appends one byte; a finish beat pads, closes the message and returns
// eight digest beats on o_valid / i_stall, word 0 first, o_last on word 7.
// Beats enter a four-entry queue, so input is taken while the engine works.
// The engine takes one byte a cycle while idle and the queue is not empty;
// the 64th byte of a block starts the rounds and then the add, and no byte is taken until they end.
// Padding shifts in one byte a cycle up to the end of the block, followed by
// the rounds and the add; with f bytes buffered, when f is 56 or more the
// length spills into a second block that is padded and compressed as well;
// then the digest leaves at one word per cycle while i_stall is low.
// A stalled result holds its word and index; the engine waits, and the queue
// keeps filling until o_stall rises.
// Reset loads the initial hash values and clears the length, the byte count
// and the queue; the message window is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_message_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last
);
    logic q_full, q_empty, q_pop;
    t_cmd q_in, q_out;

    assign q_in.op   = i_op;
    assign q_in.data = i_message_byte;
    assign o_stall   = q_full;

    sha_queue #(.DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_out)
    );

    sha_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (!q_empty),
        .i_cmd         (q_out),
        .o_cmd_pop     (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last        (o_last)
    );
endmodule
`default_nettype wire

### bench/sha256_stream_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher checker
// Watches the byte and digest channels, keeps its own SHA-256 state per
// accepted beat and compares every digest beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_checker
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_message_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_stall,
    input  wire logic [31:0] i_digest_word,
    input  wire logic [2:0]  i_word_index,
    input  wire logic        i_last,
    output int               o_errors,
    output int               o_pending,
    output logic             o_activity
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]    chain [8];
    logic [7:0]     block [64];
    logic [5:0]     fill;
    logic [63:0]    bit_len;
    t_digest_beat   digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
        end
        for (int t = 16; t < 64; t++) begin
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        end
        v = chain;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) chain[t] += v[t];
    endtask

    task automatic restart_message();
        for (int t = 0; t < 8; t++) chain[t] = INIT_H[t];
        fill = '0;
        bit_len = '0;
    endtask

    task automatic predict_beat(input logic op, input logic [7:0] data);
        int i;
        logic [63:0] total;
        t_digest_beat d;
        if (op == OP_ABSORB) begin
            block[fill] = data;
            fill = fill + 6'd1;
            if (fill == 0) begin
                compress();
                bit_len += 64'd512;
            end
        end else begin
            i = fill;
            block[i] = 8'h80;
            i++;
            if (i > 56) begin
                while (i < 64) begin block[i] = 8'h00; i++; end
                compress();
                i = 0;
            end
            while (i < 56) begin block[i] = 8'h00; i++; end
            total = bit_len + 64'(fill) * 64'd8;
            for (int k = 0; k < 8; k++) block[63-k] = total[8*k +: 8];
            compress();
            for (int k = 0; k < 8; k++) begin
                d.word = chain[k];
                d.index = 3'(k);
                d.last = (k == 7);
                digest_q.push_back(d);
            end
            restart_message();
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        o_errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_digest_beat want;
        o_activity <= (i_valid && !i_stall_in) || (i_out_valid && !i_stall);
        if (!i_rst_n) begin
            o_errors = 0;
            for (int t = 0; t < 64; t++) block[t] = '0;
            restart_message();
            digest_q.delete();
        end else begin
            if (i_valid && !i_stall_in) begin
                predict_beat(i_op, i_message_byte);
            end
            if (i_out_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    report("unexpected digest beat", i_digest_word, 32'd0);
                end else begin
                    want = digest_q.pop_front();
                    if (i_digest_word !== want.word) report("word", i_digest_word, want.word);
                    if (i_word_index !== want.index) report("index", i_word_index, want.index);
                    if (i_last !== want.last) report("last", i_last, want.last);
                end
            end
        end
        o_pending <= digest_q.size();
    end
endmodule
`default_nettype wire

### bench/tb_sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives directed and random messages with random gaps and output stalls;
// a checker beside the block predicts and compares every digest beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sha256_stream_hasher;
    import sha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  msg_byte;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
    int          errors;
    int          pending;
    logic        activity;
    logic        quiet_phase;
    int          idle_cycles;

    sha256_stream_hasher dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_op(op), .i_message_byte(msg_byte), .o_valid(out_valid), .i_stall(out_stall),
        .o_digest_word(digest_word), .o_word_index(word_index), .o_last(last)
    );

    sha256_stream_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_op(op), .i_message_byte(msg_byte), .i_out_valid(out_valid),
        .i_stall(out_stall), .i_digest_word(digest_word), .i_word_index(word_index),
        .i_last(last), .o_errors(errors), .o_pending(pending), .o_activity(activity)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one beat, with a random gap first unless in the quiet phase
    task automatic send_beat(input logic beat_op, input logic [7:0] beat_byte);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= beat_op;
        msg_byte <= beat_byte;
        do @(posedge clk); while (in_stall);
    endtask

    // stop sending until every predicted digest beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_message(input int len, input bit random_bytes, input logic [7:0] fixed);
        for (int i = 0; i < len; i++) begin
            send_beat(OP_ABSORB, random_bytes ? 8'($urandom_range(0, 255)) : fixed);
        end
        send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // receiver stalls in random bursts
    always @(posedge clk) begin
        if (!rst_n || quiet_phase) begin
            out_stall <= 1'b0;
            idle_cycles <= 0;
        end else if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            out_stall <= (idle_cycles > 1);
        end else if ($urandom_range(0, 5) == 0) begin
            idle_cycles <= $urandom_range(1, 7);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            quiet = activity ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_ABSORB;
        msg_byte = '0;
        quiet_phase = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty, "abc", short messages of byte extremes and 55/aa
        send_beat(OP_FINISH, 8'hff);
        send_beat(OP_ABSORB, 8'h61);
        send_beat(OP_ABSORB, 8'h62);
        send_beat(OP_ABSORB, 8'h63);
        send_beat(OP_FINISH, 8'h00);
        send_message(1, 1'b0, 8'h00);
        send_message(2, 1'b0, 8'hff);
        send_message(1, 1'b0, 8'h55);
        send_message(1, 1'b0, 8'haa);
        drain();

        // random: lengths around the pad boundary and across blocks
        for (int m = 0; m < 5; m++) begin
            if (m == 3) quiet_phase = 1'b1;
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 3);
                1: len = $urandom_range(54, 57);
                2: len = $urandom_range(62, 65);
                default: len = $urandom_range(0, 12);
            endcase
            send_message(len, 1'b1, 8'h00);
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
